>>> src/lfu_block_buffer_replacement_core_assert.svh
// Assertion macros used by the checker file of the block buffer.
`ifndef LFU_BLOCK_BUFFER_REPLACEMENT_CORE_ASSERT_SVH
`define LFU_BLOCK_BUFFER_REPLACEMENT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFUBB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfubb: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFUBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfubb: next-cycle check failed");

`endif

>>> src/lfubb_pkg.sv
package lfubb_pkg;

   localparam int ADDR_W = 32;
   localparam int CMD_W  = 2;
   localparam int SLOT_W = 3;
   localparam int CSR_W  = 4;

   // Access commands.
   localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DIRTY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   localparam logic [CSR_W-1:0] LINES_IN_USE_RESET = 4'd8;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic              need_fetch;
      logic              evict_valid;
      logic [ADDR_W-1:0] evict_addr;
      logic              evict_dirty;
      logic              not_resident_error;
   } rsp_type;

endpackage

>>> src/lfu_block_buffer_replacement_core.sv
// Fully associative block buffer with least-frequently-used replacement.
// Each request beat (req_cmd, req_block_addr) names a block and a command:
// get, read (fetch on a miss) or mark dirty; command 3 does nothing.
// Exactly one response beat follows each request: hit, slot, need_fetch,
// the evicted block (address and dirty flag) and a not-resident error.
// csr_wr_en/csr_wr_data set the number of usable lines; write it only
// while the block is idle. Zero acts as one, values above LINES as LINES.
// Requests are taken one at a time: req_stall is high from the accept
// until the response is loaded. The line store has one read and one write
// port and is walked one line per cycle. Except for command 3, a tag scan
// is followed by a decision step; hits and evictions then walk the lines
// once more to age the touch order, and a last step loads the response.
// Synchronous reset empties the buffer, drops any pending response beat
// and restores the line limit to 8; the memory is not cleared, since the
// valid bits guard every use. A stalled response holds its beat; the block
// finishes its work and waits with its next result until the beat leaves.
module lfu_block_buffer_replacement_core #(
   parameter int LINES      = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lfubb_pkg::CMD_W-1:0]      req_cmd,
   input  logic [lfubb_pkg::ADDR_W-1:0]     req_block_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [lfubb_pkg::SLOT_W-1:0]     rsp_slot,
   output logic                             rsp_need_fetch,
   output logic                             rsp_evict_valid,
   output logic [lfubb_pkg::ADDR_W-1:0]     rsp_evict_addr,
   output logic                             rsp_evict_dirty,
   output logic                             rsp_not_resident_error,
   input  logic                             csr_wr_en,
   input  logic [lfubb_pkg::CSR_W-1:0]      csr_wr_data
);

   localparam int IDX_W  = $clog2(LINES);
   localparam int CNT_W  = $clog2(LINES + 1);
   localparam int RANK_W = IDX_W;

   // Sequencer states.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_SWEEP  = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   // One memory word per line: tag, saturating use count, touch rank.
   typedef struct packed {
      logic [lfubb_pkg::ADDR_W-1:0] tag;
      logic [COUNT_BITS-1:0]        count;
      logic [RANK_W-1:0]            rank;
   } entry_type;

   entry_type line_mem [LINES];

   // Control state.
   logic [2:0]                   state_ff, state_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [LINES-1:0]             valid_ff, valid_in;
   logic [LINES-1:0]             dirty_ff, dirty_in;
   logic [CNT_W-1:0]             vcount_ff, vcount_in;
   logic [lfubb_pkg::CSR_W-1:0]  lines_in_use_ff, lines_in_use_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Per-request working registers.
   logic [lfubb_pkg::CMD_W-1:0]  cmd_ff, cmd_in;
   logic [lfubb_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   entry_type                    rd_data_ff;
   logic                         found_ff, found_in;
   logic [IDX_W-1:0]             hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]            hit_rank_ff, hit_rank_in;
   logic [COUNT_BITS-1:0]        hit_count_ff, hit_count_in;
   logic                         free_ff, free_in;
   logic [IDX_W-1:0]             free_idx_ff, free_idx_in;
   logic                         vic_ff, vic_in;
   logic [IDX_W-1:0]             vic_idx_ff, vic_idx_in;
   logic [COUNT_BITS-1:0]        vic_count_ff, vic_count_in;
   logic [RANK_W-1:0]            vic_rank_ff, vic_rank_in;
   logic [lfubb_pkg::ADDR_W-1:0] vic_tag_ff, vic_tag_in;
   logic [IDX_W-1:0]             tgt_idx_ff, tgt_idx_in;
   logic [RANK_W-1:0]            old_rank_ff, old_rank_in;
   entry_type                    new_ent_ff, new_ent_in;
   lfubb_pkg::rsp_type           res_ff, res_in;
   lfubb_pkg::rsp_type           rsp_ff, rsp_in;

   // Memory port controls.
   logic                         rd_en;
   logic [IDX_W-1:0]             rd_addr;
   logic                         mem_we;
   logic [IDX_W-1:0]             mem_wa;
   entry_type                    mem_wd;

   logic [7:0]                   limit;
   logic                         rd_last;

   function automatic logic [lfubb_pkg::SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [IDX_W+lfubb_pkg::SLOT_W-1:0] wide;
      wide = {{lfubb_pkg::SLOT_W{1'b0}}, idx};
      return wide[lfubb_pkg::SLOT_W-1:0];
   endfunction

   // Effective line limit, clamped to 1..LINES.
   always_comb begin
      limit = {4'b0000, lines_in_use_ff};
      if (limit == 8'd0) begin
         limit = 8'd1;
      end else if (limit > 8'(LINES)) begin
         limit = 8'(LINES);
      end
   end

   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign rd_last = (cnt_ff == CNT_W'(LINES)) && rd_pend_ff;

   always_comb begin
      entry_type d;
      entry_type aged;
      logic      v;

      state_in        = state_ff;
      rd_pend_in      = rd_pend_ff;
      valid_in        = valid_ff;
      dirty_in        = dirty_ff;
      vcount_in       = vcount_ff;
      lines_in_use_in = lines_in_use_ff;
      rsp_valid_in    = rsp_valid_ff;
      cmd_in          = cmd_ff;
      addr_in         = addr_ff;
      cnt_in          = cnt_ff;
      rd_idx_in       = rd_idx_ff;
      found_in        = found_ff;
      hit_idx_in      = hit_idx_ff;
      hit_rank_in     = hit_rank_ff;
      hit_count_in    = hit_count_ff;
      free_in         = free_ff;
      free_idx_in     = free_idx_ff;
      vic_in          = vic_ff;
      vic_idx_in      = vic_idx_ff;
      vic_count_in    = vic_count_ff;
      vic_rank_in     = vic_rank_ff;
      vic_tag_in      = vic_tag_ff;
      tgt_idx_in      = tgt_idx_ff;
      old_rank_in     = old_rank_ff;
      new_ent_in      = new_ent_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rd_en           = 1'b0;
      mem_we          = 1'b0;
      mem_wa          = rd_idx_ff;
      mem_wd          = new_ent_ff;

      d         = rd_data_ff;
      v         = valid_ff[rd_idx_ff];
      aged      = rd_data_ff;
      aged.rank = rd_data_ff.rank - RANK_W'(1);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         lines_in_use_in = csr_wr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               addr_in    = req_block_addr;
               cnt_in     = '0;
               rd_pend_in = 1'b0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               vic_in     = 1'b0;
               res_in     = '0;
               state_in   = (req_cmd == lfubb_pkg::CMD_NONE) ? S_RESP : S_SCAN;
            end
         end

         S_SCAN: begin
            if (cnt_ff != CNT_W'(LINES)) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_addr;
               cnt_in     = cnt_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
            if (rd_pend_ff) begin
               if (v && d.tag == addr_ff && !found_ff) begin
                  found_in     = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_rank_in  = d.rank;
                  hit_count_in = d.count;
               end
               if (!v && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (v && (!vic_ff || d.count < vic_count_ff ||
                         (d.count == vic_count_ff && d.rank < vic_rank_ff))) begin
                  vic_in       = 1'b1;
                  vic_idx_in   = rd_idx_ff;
                  vic_count_in = d.count;
                  vic_rank_in  = d.rank;
                  vic_tag_in   = d.tag;
               end
            end
            if (rd_last) begin
               state_in = S_DECIDE;
            end
         end

         S_DECIDE: begin
            cnt_in     = '0;
            rd_pend_in = 1'b0;
            priority if (cmd_ff == lfubb_pkg::CMD_DIRTY) begin
               if (found_ff) begin
                  dirty_in[hit_idx_ff] = 1'b1;
                  res_in.hit           = 1'b1;
                  res_in.slot          = slot_of(hit_idx_ff);
               end else begin
                  res_in.not_resident_error = 1'b1;
               end
               state_in = S_RESP;
            end else if (found_ff) begin
               tgt_idx_in       = hit_idx_ff;
               old_rank_in      = hit_rank_ff;
               new_ent_in.tag   = addr_ff;
               new_ent_in.count = (hit_count_ff == '1) ? hit_count_ff
                                                       : hit_count_ff + COUNT_BITS'(1);
               new_ent_in.rank  = RANK_W'(vcount_ff - CNT_W'(1));
               res_in.hit       = 1'b1;
               res_in.slot      = slot_of(hit_idx_ff);
               state_in         = S_SWEEP;
            end else if (8'(vcount_ff) >= limit) begin
               // Full: the victim's line is dropped and refilled in place.
               tgt_idx_in          = vic_idx_ff;
               old_rank_in         = vic_rank_ff;
               new_ent_in.tag      = addr_ff;
               new_ent_in.count    = COUNT_BITS'(1);
               new_ent_in.rank     = RANK_W'(vcount_ff - CNT_W'(1));
               dirty_in[vic_idx_ff] = 1'b0;
               res_in.slot         = slot_of(vic_idx_ff);
               res_in.need_fetch   = (cmd_ff == lfubb_pkg::CMD_READ);
               res_in.evict_valid  = 1'b1;
               res_in.evict_addr   = vic_tag_ff;
               res_in.evict_dirty  = dirty_ff[vic_idx_ff];
               state_in            = S_SWEEP;
            end else begin
               // Room left: fill the lowest free line as the newest one.
               mem_we                = 1'b1;
               mem_wa                = free_idx_ff;
               mem_wd.tag            = addr_ff;
               mem_wd.count          = COUNT_BITS'(1);
               mem_wd.rank           = RANK_W'(vcount_ff);
               valid_in[free_idx_ff] = 1'b1;
               dirty_in[free_idx_ff] = 1'b0;
               vcount_in             = vcount_ff + CNT_W'(1);
               res_in.slot           = slot_of(free_idx_ff);
               res_in.need_fetch     = (cmd_ff == lfubb_pkg::CMD_READ);
               state_in              = S_RESP;
            end
         end

         S_SWEEP: begin
            if (cnt_ff != CNT_W'(LINES)) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_addr;
               cnt_in     = cnt_ff + CNT_W'(1);
               rd_pend_in = 1'b1;
            end else begin
               rd_pend_in = 1'b0;
            end
            // Lines newer than the one that moved shift down one place.
            if (rd_pend_ff) begin
               if (rd_idx_ff == tgt_idx_ff) begin
                  mem_we = 1'b1;
                  mem_wd = new_ent_ff;
               end else if (v && d.rank > old_rank_ff) begin
                  mem_we = 1'b1;
                  mem_wd = aged;
               end
            end
            if (rd_last) begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rd_pend_ff      <= 1'b0;
         valid_ff        <= '0;
         dirty_ff        <= '0;
         vcount_ff       <= '0;
         lines_in_use_ff <= lfubb_pkg::LINES_IN_USE_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rd_pend_ff      <= rd_pend_in;
         valid_ff        <= valid_in;
         dirty_ff        <= dirty_in;
         vcount_ff       <= vcount_in;
         lines_in_use_ff <= lines_in_use_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      rd_idx_ff    <= rd_idx_in;
      found_ff     <= found_in;
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_count_ff <= hit_count_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      vic_ff       <= vic_in;
      vic_idx_ff   <= vic_idx_in;
      vic_count_ff <= vic_count_in;
      vic_rank_ff  <= vic_rank_in;
      vic_tag_ff   <= vic_tag_in;
      tgt_idx_ff   <= tgt_idx_in;
      old_rank_ff  <= old_rank_in;
      new_ent_ff   <= new_ent_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // Line store: one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (mem_we) begin
         line_mem[mem_wa] <= mem_wd;
      end
   end

   assign req_stall              = (state_ff != S_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_hit                = rsp_ff.hit;
   assign rsp_slot               = rsp_ff.slot;
   assign rsp_need_fetch         = rsp_ff.need_fetch;
   assign rsp_evict_valid        = rsp_ff.evict_valid;
   assign rsp_evict_addr         = rsp_ff.evict_addr;
   assign rsp_evict_dirty        = rsp_ff.evict_dirty;
   assign rsp_not_resident_error = rsp_ff.not_resident_error;

endmodule

>>> src/lfubb_checker.sv
`include "lfu_block_buffer_replacement_core_assert.svh"

module lfubb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_hit,
   input logic [lfubb_pkg::SLOT_W-1:0] rsp_slot,
   input logic                         rsp_need_fetch,
   input logic                         rsp_evict_valid,
   input logic [lfubb_pkg::ADDR_W-1:0] rsp_evict_addr,
   input logic                         rsp_not_resident_error
);

   logic [lfubb_pkg::ADDR_W+lfubb_pkg::SLOT_W:0] rsp_payload;
   logic                                         hit_conflict;

   assign rsp_payload  = {rsp_hit, rsp_slot, rsp_evict_addr};
   assign hit_conflict = rsp_need_fetch || rsp_evict_valid || rsp_not_resident_error;

   // A stalled response beat stays and keeps its payload.
   `LFUBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `LFUBB_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // Requests are processed one at a time.
   `LFUBB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A hit never fetches, evicts or reports a missing block.
   `LFUBB_ASSERT_SAME(a_hit_exclusive, clock, reset, rsp_valid && rsp_hit, !hit_conflict)

endmodule

bind lfu_block_buffer_replacement_core lfubb_checker u_lfubb_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_valid              (req_valid),
   .req_stall              (req_stall),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_hit                (rsp_hit),
   .rsp_slot               (rsp_slot),
   .rsp_need_fetch         (rsp_need_fetch),
   .rsp_evict_valid        (rsp_evict_valid),
   .rsp_evict_addr         (rsp_evict_addr),
   .rsp_not_resident_error (rsp_not_resident_error)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the LFU block buffer. Access beats come from a queue
// that an initial block fills at time zero. A clocked driver sends them and
// predicts the response of every accepted beat. A clocked monitor compares each
// response beat field by field with the oldest prediction.
module testbench;

   localparam int LINES      = 8;
   localparam int COUNT_BITS = 16;
   localparam int RANK_W     = $clog2(LINES);
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 115;
   localparam int CMD_W      = lfubb_pkg::CMD_W;
   localparam int ADDR_W     = lfubb_pkg::ADDR_W;
   localparam int SLOT_W     = lfubb_pkg::SLOT_W;
   localparam int CSR_W      = lfubb_pkg::CSR_W;

   // The queue holds three kinds of entry. An access is sent as a beat. A limit
   // change and a pause both wait until the block has answered everything.
   typedef enum logic [1:0] {STEP_ACCESS, STEP_LIMIT, STEP_PAUSE} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [CMD_W-1:0]   cmd;
      logic [ADDR_W-1:0]  addr;
      logic [CSR_W-1:0]   limit;
   } step_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CMD_W-1:0]    req_cmd = lfubb_pkg::CMD_NONE;
   logic [ADDR_W-1:0]   req_block_addr = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_need_fetch;
   logic                rsp_evict_valid;
   logic [ADDR_W-1:0]   rsp_evict_addr;
   logic                rsp_evict_dirty;
   logic                rsp_not_resident_error;
   logic                csr_wr_en = 1'b0;
   logic [CSR_W-1:0]    csr_wr_data = '0;

   step_type           pending[$];
   lfubb_pkg::rsp_type expected[$];

   // Beat counters. sent and answered each have a single writer and are updated
   // with a nonblocking assignment, so the other side always reads a settled value.
   int sent = 0;
   int answered = 0;
   bit quiet_tail = 1'b0;
   int mismatches = 0;

   // Idle bookkeeping that only the driver or only the monitor touches.
   int gap_left = 0;
   int calm_left = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int pct_timer = 0;

   // Mirror of the buffer state that the predictor works on.
   logic                    occupied [LINES];
   logic [ADDR_W-1:0]       tag_of   [LINES];
   logic                    modified [LINES];
   logic [COUNT_BITS-1:0]   freq     [LINES];
   logic [RANK_W-1:0]       recency  [LINES];
   logic [CSR_W-1:0]        limit_cfg = lfubb_pkg::LINES_IN_USE_RESET;

   // What the run went through, for the closing summary.
   int hits_seen = 0;
   int evictions_seen = 0;
   int writebacks_seen = 0;
   int orphan_marks_seen = 0;
   int limits_seen = 0;

   lfu_block_buffer_replacement_core #(
      .LINES      (LINES),
      .COUNT_BITS (COUNT_BITS)
   ) i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_cmd                (req_cmd),
      .req_block_addr         (req_block_addr),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_hit                (rsp_hit),
      .rsp_slot               (rsp_slot),
      .rsp_need_fetch         (rsp_need_fetch),
      .rsp_evict_valid        (rsp_evict_valid),
      .rsp_evict_addr         (rsp_evict_addr),
      .rsp_evict_dirty        (rsp_evict_dirty),
      .rsp_not_resident_error (rsp_not_resident_error),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Reset is held high at the start and never raised again.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // A run that hangs ends here. The slowest honest run is far shorter.
   initial begin
      #1000000;
      $display("testbench: done, errors");
      $finish;
   end

   function automatic int count_occupied();
      int n;
      n = 0;
      for (int i = 0; i < LINES; i++)
         if (occupied[i])
            n++;
      return n;
   endfunction

   // Works out the response to one access and moves the mirrored state on.
   // The victim is the valid line with the lowest use count; among equal
   // counts it is the line that was last touched (hit or filled) longest ago.
   function automatic lfubb_pkg::rsp_type predict_access(logic [CMD_W-1:0] cmd,
                                                         logic [ADDR_W-1:0] addr);
      lfubb_pkg::rsp_type r;
      int                 way;
      int                 cap;
      bit                 found;
      bit                 have;
      logic [RANK_W-1:0]  old_rank;
      r = '0;
      way = 0;
      found = 1'b0;
      if (cmd == lfubb_pkg::CMD_NONE)
         return r;
      for (int i = 0; i < LINES; i++) begin
         if (!found && occupied[i] && tag_of[i] == addr) begin
            way = i;
            found = 1'b1;
         end
      end
      if (cmd == lfubb_pkg::CMD_DIRTY) begin
         if (!found) begin
            r.not_resident_error = 1'b1;
            orphan_marks_seen++;
         end else begin
            modified[way] = 1'b1;
            r.hit = 1'b1;
            r.slot = SLOT_W'(way);
         end
         return r;
      end
      if (found) begin
         // A hit bumps the count (it sticks at all ones) and makes the line
         // the newest one, even when the count could not move.
         if (freq[way] != '1)
            freq[way]++;
         old_rank = recency[way];
         for (int j = 0; j < LINES; j++)
            if (j != way && occupied[j] && recency[j] > old_rank)
               recency[j]--;
         recency[way] = RANK_W'(count_occupied() - 1);
         r.hit = 1'b1;
         r.slot = SLOT_W'(way);
         hits_seen++;
         return r;
      end
      // A limit of zero behaves as one, and anything above the line count
      // behaves as the line count.
      cap = (limit_cfg == 0) ? 1 : (limit_cfg > LINES) ? LINES : int'(limit_cfg);
      if (count_occupied() >= cap) begin
         // Only one line goes per miss, even when the limit was lowered below
         // the number of lines already in use.
         have = 1'b0;
         for (int i = 0; i < LINES; i++) begin
            if (occupied[i] && (!have || freq[i] < freq[way] ||
                (freq[i] == freq[way] && recency[i] < recency[way]))) begin
               way = i;
               have = 1'b1;
            end
         end
         r.evict_valid = 1'b1;
         r.evict_addr = tag_of[way];
         r.evict_dirty = modified[way];
         evictions_seen++;
         if (modified[way])
            writebacks_seen++;
         old_rank = recency[way];
         occupied[way] = 1'b0;
         for (int j = 0; j < LINES; j++)
            if (occupied[j] && recency[j] > old_rank)
               recency[j]--;
      end else begin
         have = 1'b0;
         for (int i = 0; i < LINES; i++) begin
            if (!have && !occupied[i]) begin
               way = i;
               have = 1'b1;
            end
         end
      end
      recency[way] = RANK_W'(count_occupied());
      occupied[way] = 1'b1;
      modified[way] = 1'b0;
      tag_of[way] = addr;
      freq[way] = 1;
      r.slot = SLOT_W'(way);
      r.need_fetch = (cmd == lfubb_pkg::CMD_READ);
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("%0t: response beat %0d, %s: got %0h, expected %0h",
               $time, answered, what, got, want);
   endtask

   task automatic compare_beat(lfubb_pkg::rsp_type got, lfubb_pkg::rsp_type want);
      if (got.hit !== want.hit)
         report_mismatch("hit", got.hit, want.hit);
      if (got.slot !== want.slot)
         report_mismatch("slot", got.slot, want.slot);
      if (got.need_fetch !== want.need_fetch)
         report_mismatch("need_fetch", got.need_fetch, want.need_fetch);
      if (got.evict_valid !== want.evict_valid)
         report_mismatch("evict_valid", got.evict_valid, want.evict_valid);
      if (got.evict_addr !== want.evict_addr)
         report_mismatch("evict_addr", got.evict_addr, want.evict_addr);
      if (got.evict_dirty !== want.evict_dirty)
         report_mismatch("evict_dirty", got.evict_dirty, want.evict_dirty);
      if (got.not_resident_error !== want.not_resident_error)
         report_mismatch("not_resident_error", got.not_resident_error,
                         want.not_resident_error);
   endtask

   task automatic queue_access(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr);
      step_type s;
      s = '0;
      s.kind = STEP_ACCESS;
      s.cmd = cmd;
      s.addr = addr;
      pending.insert(pending.size(), s);
   endtask

   task automatic queue_limit(logic [CSR_W-1:0] value);
      step_type s;
      s = '0;
      s.kind = STEP_LIMIT;
      s.limit = value;
      pending.insert(pending.size(), s);
   endtask

   // Driver. A request beat stays on the port, unchanged, until the block
   // takes it. Every port gets at most one nonblocking assignment per edge,
   // so back-to-back beats keep valid high without a glitch.
   always @(posedge clock) begin
      logic              next_valid;
      logic [CMD_W-1:0]  next_cmd;
      logic [ADDR_W-1:0] next_addr;
      logic              next_wr;
      step_type          head;
      if (reset) begin
         req_valid <= 1'b0;
         req_cmd <= lfubb_pkg::CMD_NONE;
         req_block_addr <= '0;
         csr_wr_en <= 1'b0;
         csr_wr_data <= '0;
      end else begin
         next_valid = req_valid;
         next_cmd = req_cmd;
         next_addr = req_block_addr;
         next_wr = 1'b0;
         if (req_valid && !req_stall) begin
            expected.insert(expected.size(), predict_access(req_cmd, req_block_addr));
            sent <= sent + 1;
            next_valid = 1'b0;
            // Now and then a stretch of items goes without any gap;
            // otherwise a burst of idle cycles may follow the beat.
            if (calm_left != 0)
               calm_left--;
            else if ($urandom_range(0, 99) < 3)
               calm_left = $urandom_range(20, 60);
            else if (!quiet_tail && $urandom_range(0, 99) < 30)
               gap_left = $urandom_range(1, 11);
         end
         if (!next_valid) begin
            if (gap_left != 0 && !quiet_tail) begin
               gap_left--;
            end else if (pending.size() != 0) begin
               head = pending[0];
               if (head.kind == STEP_ACCESS) begin
                  pending.delete(0);
                  next_valid = 1'b1;
                  next_cmd = head.cmd;
                  next_addr = head.addr;
               end else if (!req_valid && !csr_wr_en && sent == answered) begin
                  // The block has answered every beat, so it is idle and the
                  // line limit may change.
                  pending.delete(0);
                  if (head.kind == STEP_LIMIT) begin
                     next_wr = 1'b1;
                     csr_wr_data <= head.limit;
                     limit_cfg = head.limit;
                     limits_seen++;
                  end
               end
            end
         end
         quiet_tail <= (pending.size() < 120);
         req_valid <= next_valid;
         req_cmd <= next_cmd;
         req_block_addr <= next_addr;
         csr_wr_en <= next_wr;
      end
   end

   // Monitor. It checks every accepted response beat and stalls the response
   // channel in random bursts. The stall rate is redrawn every so often, and
   // one of the rates is zero, so some stretches see no stall at all.
   always @(posedge clock) begin
      lfubb_pkg::rsp_type got;
      lfubb_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            answered <= answered + 1;
            got = '0;
            got.hit = rsp_hit;
            got.slot = rsp_slot;
            got.need_fetch = rsp_need_fetch;
            got.evict_valid = rsp_evict_valid;
            got.evict_addr = rsp_evict_addr;
            got.evict_dirty = rsp_evict_dirty;
            got.not_resident_error = rsp_not_resident_error;
            if (expected.size() == 0) begin
               report_mismatch("beat with nothing expected", 1, 0);
            end else begin
               want = expected[0];
               expected.delete(0);
               compare_beat(got, want);
            end
         end
         if (pct_timer == 0) begin
            pct_timer = 150;
            case ($urandom_range(0, 2))
               0: begin
                  stall_pct = 0;
               end
               1: begin
                  stall_pct = 6;
               end
               default: begin
                  stall_pct = 25;
               end
            endcase
         end else begin
            pct_timer--;
         end
         if (stall_left != 0 && !quiet_tail) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, then the wait for the last response and the verdict.
   initial begin
      logic [ADDR_W-1:0] pool [16];
      int                limits [PHASES];
      int                pool_n;
      int                idx;
      int                pick;
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] addr;
      step_type          pause;

      for (int i = 0; i < LINES; i++) begin
         occupied[i] = 1'b0;
         modified[i] = 1'b0;
         tag_of[i] = '0;
         freq[i] = '0;
         recency[i] = '0;
      end
      limits = '{8, 1, 15, 0, 3, 8, 2, 5, 6, 7};
      pause = '0;
      pause.kind = STEP_PAUSE;

      // Directed part with the reset limit of eight lines. A dirty mark on an
      // empty buffer is an error, and command 3 does nothing.
      queue_access(lfubb_pkg::CMD_DIRTY, 32'h0000_0000);
      queue_access(lfubb_pkg::CMD_NONE, 32'hFFFF_FFFF);
      queue_access(lfubb_pkg::CMD_GET, 32'h0000_0000);
      queue_access(lfubb_pkg::CMD_READ, 32'hFFFF_FFFF);
      queue_access(lfubb_pkg::CMD_GET, 32'h5555_5555);
      queue_access(lfubb_pkg::CMD_READ, 32'hAAAA_AAAA);
      queue_access(lfubb_pkg::CMD_READ, 32'hFFFF_FFFF);
      queue_access(lfubb_pkg::CMD_GET, 32'h0000_0000);
      queue_access(lfubb_pkg::CMD_DIRTY, 32'hAAAA_AAAA);
      queue_access(lfubb_pkg::CMD_NONE, 32'h0000_0000);
      for (int i = 1; i <= 4; i++)
         queue_access(lfubb_pkg::CMD_GET, ADDR_W'(i));
      // The buffer is full. The next two misses take the oldest lines among
      // those used once: first a clean one, then the dirty one.
      queue_access(lfubb_pkg::CMD_READ, 32'h1234_5678);
      queue_access(lfubb_pkg::CMD_READ, 32'h9ABC_DEF0);
      queue_access(lfubb_pkg::CMD_DIRTY, 32'h5555_5555);
      queue_access(lfubb_pkg::CMD_DIRTY, 32'h0000_0000);
      queue_access(lfubb_pkg::CMD_READ, 32'h1234_5678);
      // With the limit lowered to one, every miss still evicts just one line
      // while the other lines stay valid.
      queue_limit(4'd1);
      queue_access(lfubb_pkg::CMD_GET, 32'h0000_FFFF);
      queue_access(lfubb_pkg::CMD_GET, 32'hFFFF_0000);
      queue_access(lfubb_pkg::CMD_DIRTY, 32'hFFFF_0000);
      queue_access(lfubb_pkg::CMD_READ, 32'h0000_FFFF);

      // Random phases, one per line limit. Most addresses come from a small
      // pool, skewed toward its first entries, so that counts spread out and
      // hits, ties and evictions all happen often.
      for (int p = 0; p < PHASES; p++) begin
         queue_limit(CSR_W'(limits[p]));
         pool_n = $urandom_range(2, 14);
         for (int k = 0; k < pool_n; k++) begin
            case ($urandom_range(0, 3))
               0: begin
                  pool[k] = ~ADDR_W'($urandom_range(0, 15));
               end
               1: begin
                  pool[k] = ADDR_W'($urandom_range(0, 15));
               end
               default: begin
                  pool[k] = $urandom;
               end
            endcase
         end
         for (int i = 0; i < PHASE_LEN; i++) begin
            if (i == PHASE_LEN / 2 && (p == 0 || $urandom_range(0, 1) == 1))
               pending.insert(pending.size(), pause);
            pick = $urandom_range(0, 99);
            cmd = (pick < 36) ? lfubb_pkg::CMD_GET : (pick < 72) ? lfubb_pkg::CMD_READ :
                  (pick < 93) ? lfubb_pkg::CMD_DIRTY : lfubb_pkg::CMD_NONE;
            idx = $urandom_range(0, pool_n - 1);
            if ($urandom_range(0, 1) == 1)
               idx = idx / 2;
            addr = ($urandom_range(0, 99) < 88) ? pool[idx] : ADDR_W'($urandom);
            queue_access(cmd, addr);
         end
      end

      @(negedge clock);
      while (reset || pending.size() != 0 || req_valid || csr_wr_en ||
             expected.size() != 0)
         @(negedge clock);
      // A late or extra response beat would show up within this window.
      repeat (50) @(negedge clock);
      if (expected.size() != 0)
         report_mismatch("responses still missing", expected.size(), 0);

      $display("summary: %0d access beats under %0d line limits, %0d hits,",
               sent, limits_seen, hits_seen);
      $display("summary: %0d evictions (%0d dirty), %0d marks of absent blocks",
               evictions_seen, writebacks_seen, orphan_marks_seen);
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
